// ===== src/dpp_pkg.sv =====
// Shared types and constants of the depth point projector.
`default_nettype none

package dpp_pkg;

    localparam int COORD_W  = 16;
    localparam int Z_W      = COORD_W - 1;
    localparam int FOCAL_W  = 24;
    localparam int CENTER_W = 20;
    localparam int SIZE_W   = 12;
    localparam int QUOT_W   = SIZE_W;
    localparam int CODE_W   = 8;
    localparam int FRAC_W   = 8;
    localparam int INDEX_W  = 3;
    localparam int WDATA_W  = FOCAL_W;

    localparam int PROD_W = FOCAL_W + 1 + COORD_W;
    localparam int CZ_W   = CENTER_W + Z_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int MAG_W  = NUM_W - FRAC_W;
    localparam int REM_W  = Z_W + QUOT_W;

    localparam int DIV_BITS     = 3;
    localparam int DIV_STAGES   = QUOT_W / DIV_BITS;
    localparam int FRONT_STAGES = 4;
    localparam int LAST_STAGE   = FRONT_STAGES + DIV_STAGES - 1;

    localparam int MAX_RANGE_MM = 4500;
    localparam int DEPTH_FULL   = 255;
    localparam int DEPTH_N_W    = Z_W + CODE_W;
    localparam int RECIP_SHIFT  = 32;
    localparam int RECIP_W      = 25;
    localparam int DPROD_W      = DEPTH_N_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DEPTH_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / MAX_RANGE_MM);

    localparam logic [FOCAL_W-1:0]  FOCAL_X_RST  = FOCAL_W'(131072);
    localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST  = FOCAL_W'(131072);
    localparam logic [CENTER_W-1:0] CENTER_X_RST = CENTER_W'(40960);
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = CENTER_W'(23040);
    localparam logic [SIZE_W-1:0]   WIDTH_RST    = SIZE_W'(320);
    localparam logic [SIZE_W-1:0]   HEIGHT_RST   = SIZE_W'(180);

    typedef enum logic [INDEX_W-1:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic              in_view;
        logic [SIZE_W-1:0] pixel_col;
        logic [SIZE_W-1:0] pixel_row;
        logic [CODE_W-1:0] depth_code;
    } result_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [WDATA_W-1:0] wdata;
    } cfg_word_t;

    typedef struct packed {
        logic [FOCAL_W-1:0]  focal_x;
        logic [FOCAL_W-1:0]  focal_y;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [SIZE_W-1:0]   image_width;
        logic [SIZE_W-1:0]   image_height;
    } cfg_regs_t;

endpackage

`default_nettype wire

// ===== src/dpp_stream_if.sv =====
// Valid/ready channel carrying one word of a given payload type.
`default_nettype none

interface dpp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/depth_point_projector_core.sv =====
// Top level of the depth point projector: pinhole projection of streamed 3D points.
//
// Channels: "point" takes one word per point (point_x, point_y, point_z in mm,
// signed). "result" gives one word per point (in_view, pixel_col, pixel_row,
// depth_code), in input order. "cfg" writes the six intrinsic and image size
// registers by index; it is always ready, and the user must write it only while
// idle, as the block itself does not enforce this. Throughput: one point per
// cycle while result.ready is not held low; the eight stage pipeline holds the
// divide by depth as four stages of three restoring steps each.
// Reset: all pipeline valid bits and the output valid bit clear, the registers take
// their default intrinsics (320 x 180 image).
// Stall: a low result.ready holds the output word; upstream stages keep
// filling their bubbles, and point.ready falls only once every stage holds a
// word. Nothing is dropped or repeated.
`default_nettype none

module depth_point_projector_core (
    input  logic       clk,
    input  logic       rst_n,
    dpp_stream_if.sink   point,
    dpp_stream_if.sink   cfg,
    dpp_stream_if.source result
);
    import dpp_pkg::*;

    cfg_regs_t            regs;
    logic [LAST_STAGE:0]  adv;
    logic                 adv_out;
    logic [LAST_STAGE:0]  valid_in;
    logic [LAST_STAGE:0]  valid_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;
    result_t              out_data_next;

    logic [QUOT_W-1:0]    quot_x;
    logic [QUOT_W-1:0]    quot_y;
    logic                 miss_x;
    logic                 miss_y;
    logic [CODE_W-1:0]    code;
    logic                 zpos;
    logic                 view;

    dpp_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    dpp_axis_proj u_axis_x (
        .clk     (clk),
        .adv     (adv),
        .focal   (regs.focal_x),
        .center  (regs.center_x),
        .coord   (point.data.point_x),
        .point_z (point.data.point_z),
        .quot    (quot_x),
        .miss    (miss_x)
    );

    dpp_axis_proj u_axis_y (
        .clk     (clk),
        .adv     (adv),
        .focal   (regs.focal_y),
        .center  (regs.center_y),
        .coord   (point.data.point_y),
        .point_z (point.data.point_z),
        .quot    (quot_y),
        .miss    (miss_y)
    );

    dpp_depth_code u_depth (
        .clk     (clk),
        .adv     (adv),
        .point_z (point.data.point_z),
        .code    (code),
        .zpos    (zpos)
    );

    assign adv_out = !out_valid_reg || result.ready;

    always_comb
    begin
        adv[LAST_STAGE] = !valid_reg[LAST_STAGE] || adv_out;
        for (int k = LAST_STAGE - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign valid_in    = {valid_reg[LAST_STAGE-1:0], point.valid};
    assign point.ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k <= LAST_STAGE; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_in[k];
                end
            end
            if (adv_out)
            begin
                out_valid_reg <= valid_reg[LAST_STAGE];
            end
        end
    end

    assign view = zpos && !miss_x && !miss_y
               && (quot_x < regs.image_width) && (quot_y < regs.image_height);

    always_comb
    begin
        out_data_next.in_view    = view;
        out_data_next.pixel_col  = view ? quot_x : '0;
        out_data_next.pixel_row  = view ? quot_y : '0;
        out_data_next.depth_code = code;
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

`default_nettype wire

// ===== src/dpp_cfg_regs.sv =====
// Configuration register file of the depth point projector.
`default_nettype none

module dpp_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    dpp_stream_if.sink          cfg,
    output dpp_pkg::cfg_regs_t  regs
);
    import dpp_pkg::*;

    cfg_regs_t cfg_regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = cfg_regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.focal_x      <= FOCAL_X_RST;
            cfg_regs_reg.focal_y      <= FOCAL_Y_RST;
            cfg_regs_reg.center_x     <= CENTER_X_RST;
            cfg_regs_reg.center_y     <= CENTER_Y_RST;
            cfg_regs_reg.image_width  <= WIDTH_RST;
            cfg_regs_reg.image_height <= HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_index_t'(cfg.data.index))
                REG_FOCAL_X:      cfg_regs_reg.focal_x      <= cfg.data.wdata;
                REG_FOCAL_Y:      cfg_regs_reg.focal_y      <= cfg.data.wdata;
                REG_CENTER_X:     cfg_regs_reg.center_x     <= cfg.data.wdata[CENTER_W-1:0];
                REG_CENTER_Y:     cfg_regs_reg.center_y     <= cfg.data.wdata[CENTER_W-1:0];
                REG_IMAGE_WIDTH:  cfg_regs_reg.image_width  <= cfg.data.wdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_regs_reg.image_height <= cfg.data.wdata[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/dpp_axis_proj.sv =====
// One image axis: focal product, centre term, magnitude and pipelined divide by depth.
`default_nettype none

module dpp_axis_proj (
    input  logic                                clk,
    input  logic [dpp_pkg::LAST_STAGE:0]        adv,
    input  logic [dpp_pkg::FOCAL_W-1:0]         focal,
    input  logic [dpp_pkg::CENTER_W-1:0]        center,
    input  logic signed [dpp_pkg::COORD_W-1:0]  coord,
    input  logic signed [dpp_pkg::COORD_W-1:0]  point_z,
    output logic [dpp_pkg::QUOT_W-1:0]          quot,
    output logic                                miss
);
    import dpp_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic [CZ_W-1:0]          cz_reg;
    logic [Z_W-1:0]           z0_reg;

    logic signed [NUM_W-1:0]  num_reg;
    logic [Z_W-1:0]           z1_reg;

    logic [NUM_W-1:0]         mag;
    logic [MAG_W-1:0]         mag8_reg;
    logic                     neg2_reg;
    logic [Z_W-1:0]           z2_reg;

    logic [REM_W-1:0]         rem3_reg;
    logic                     ovf3_reg;
    logic                     neg3_reg;
    logic [Z_W-1:0]           z3_reg;

    logic [REM_W-1:0]         div_rem_reg  [DIV_STAGES-1];
    logic [Z_W-1:0]           div_z_reg    [DIV_STAGES-1];
    logic [QUOT_W-1:0]        div_quot_reg [DIV_STAGES];
    logic                     div_neg_reg  [DIV_STAGES];
    logic                     div_ovf_reg  [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg <= PROD_W'($signed({1'b0, focal})) * PROD_W'(coord);
            cz_reg   <= CZ_W'(center) * CZ_W'(point_z[Z_W-1:0]);
            z0_reg   <= point_z[Z_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            num_reg <= $signed({prod_reg[PROD_W-1], prod_reg})
                     + $signed({{(NUM_W-CZ_W){1'b0}}, cz_reg});
            z1_reg  <= z0_reg;
        end
    end

    assign mag = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            mag8_reg <= mag[NUM_W-1:FRAC_W];
            neg2_reg <= num_reg[NUM_W-1];
            z2_reg   <= z1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            ovf3_reg <= mag8_reg >= {{(MAG_W-REM_W){1'b0}}, z2_reg, {QUOT_W{1'b0}}};
            rem3_reg <= mag8_reg[REM_W-1:0];
            neg3_reg <= neg2_reg;
            z3_reg   <= z2_reg;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  rem_out;
        logic [QUOT_W-1:0] quot_in;
        logic [QUOT_W-1:0] quot_out;
        logic [Z_W-1:0]    z_in;
        logic              neg_in;
        logic              ovf_in;

        if (s == 0)
        begin : g_first
            assign rem_in  = rem3_reg;
            assign quot_in = '0;
            assign z_in    = z3_reg;
            assign neg_in  = neg3_reg;
            assign ovf_in  = ovf3_reg;
        end
        else
        begin : g_next
            assign rem_in  = div_rem_reg[s-1];
            assign quot_in = div_quot_reg[s-1];
            assign z_in    = div_z_reg[s-1];
            assign neg_in  = div_neg_reg[s-1];
            assign ovf_in  = div_ovf_reg[s-1];
        end

        always_comb
        begin : step
            logic [REM_W-1:0] trial;
            rem_out  = rem_in;
            quot_out = quot_in;
            for (int j = 0; j < DIV_BITS; j++)
            begin
                trial = {{QUOT_W{1'b0}}, z_in} << (QUOT_W - 1 - s * DIV_BITS - j);
                if (rem_out >= trial)
                begin
                    rem_out = rem_out - trial;
                    quot_out[QUOT_W - 1 - s * DIV_BITS - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[FRONT_STAGES + s])
            begin
                div_quot_reg[s] <= quot_out;
                div_neg_reg[s]  <= neg_in;
                div_ovf_reg[s]  <= ovf_in;
            end
        end

        if (s < DIV_STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv[FRONT_STAGES + s])
                begin
                    div_rem_reg[s] <= rem_out;
                    div_z_reg[s]   <= z_in;
                end
            end
        end
    end

    assign quot = div_quot_reg[DIV_STAGES-1];
    assign miss = div_ovf_reg[DIV_STAGES-1]
               || (div_neg_reg[DIV_STAGES-1] && (quot != '0));

endmodule

`default_nettype wire

// ===== src/dpp_depth_code.sv =====
// Depth code ramp: reciprocal multiply with one correction, then delay line.
`default_nettype none

module dpp_depth_code (
    input  logic                                clk,
    input  logic [dpp_pkg::LAST_STAGE:0]        adv,
    input  logic signed [dpp_pkg::COORD_W-1:0]  point_z,
    output logic [dpp_pkg::CODE_W-1:0]          code,
    output logic                                zpos
);
    import dpp_pkg::*;

    logic                 zpos_in;
    logic                 near_in;
    logic [Z_W-1:0]       span_in;

    logic [DEPTH_N_W-1:0] n0_reg;
    logic                 live0_reg;
    logic                 zpos0_reg;

    logic [DPROD_W-1:0]   prod1_reg;
    logic [DEPTH_N_W-1:0] n1_reg;
    logic                 live1_reg;
    logic                 zpos1_reg;

    logic [CODE_W-1:0]    q2_reg;
    logic [DEPTH_N_W-1:0] r2_reg;
    logic                 live2_reg;
    logic                 zpos2_reg;

    logic [CODE_W-1:0]    code_line_reg [DIV_STAGES+1];
    logic                 zpos_line_reg [DIV_STAGES+1];

    assign zpos_in = !point_z[COORD_W-1] && (point_z != '0);
    assign near_in = point_z < $signed(COORD_W'(MAX_RANGE_MM));
    assign span_in = Z_W'(MAX_RANGE_MM) - point_z[Z_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            n0_reg    <= DEPTH_N_W'(span_in) * DEPTH_N_W'(DEPTH_FULL);
            live0_reg <= zpos_in && near_in;
            zpos0_reg <= zpos_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            prod1_reg <= DPROD_W'(n0_reg) * DPROD_W'(DEPTH_RECIP);
            n1_reg    <= n0_reg;
            live1_reg <= live0_reg;
            zpos1_reg <= zpos0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            q2_reg    <= prod1_reg[RECIP_SHIFT +: CODE_W];
            r2_reg    <= n1_reg - DEPTH_N_W'(prod1_reg[RECIP_SHIFT +: CODE_W])
                                * DEPTH_N_W'(MAX_RANGE_MM);
            live2_reg <= live1_reg;
            zpos2_reg <= zpos1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            code_line_reg[0] <= live2_reg
                ? q2_reg + CODE_W'(r2_reg >= DEPTH_N_W'(MAX_RANGE_MM))
                : '0;
            zpos_line_reg[0] <= zpos2_reg;
        end
    end

    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_line
        always_ff @(posedge clk)
        begin
            if (adv[FRONT_STAGES - 1 + s])
            begin
                code_line_reg[s] <= code_line_reg[s-1];
                zpos_line_reg[s] <= zpos_line_reg[s-1];
            end
        end
    end

    assign code = code_line_reg[DIV_STAGES];
    assign zpos = zpos_line_reg[DIV_STAGES];

endmodule

`default_nettype wire

// ===== tb/sv/depth_projection_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the depth point projector: predicts each point's result word and compares.
module depth_projection_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    input  logic               point_ready,
    input  dpp_pkg::point_t    point_word,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  dpp_pkg::cfg_word_t cfg_word,
    input  logic               result_valid,
    input  logic               result_ready,
    input  dpp_pkg::result_t   result_word,
    output int                 mismatches,
    output int                 outstanding,
    output int                 checked,
    output int                 visible
);
    import dpp_pkg::*;

    localparam longint RANGE_MM  = 4500;
    localparam longint CODE_FULL = 255;
    localparam longint SUBPIXEL  = 256;

    cfg_regs_t intrinsics;
    result_t   projected_words[$];
    result_t   oldest;

    function automatic result_t project_point(point_t p, cfg_regs_t k);
        longint  px;
        longint  py;
        longint  pz;
        longint  col;
        longint  row;
        longint  ramp;
        longint  cols;
        longint  rows;
        result_t r;
        px   = p.point_x;
        py   = p.point_y;
        pz   = p.point_z;
        cols = k.image_width;
        rows = k.image_height;
        r    = '0;
        if (pz > 0)
        begin
            col  = (longint'(k.focal_x) * px + longint'(k.center_x) * pz) / (pz * SUBPIXEL);
            row  = (longint'(k.focal_y) * py + longint'(k.center_y) * pz) / (pz * SUBPIXEL);
            ramp = (pz * CODE_FULL + RANGE_MM - 1) / RANGE_MM;
            r.depth_code = (ramp >= CODE_FULL) ? '0 : CODE_W'(CODE_FULL - ramp);
            if (col >= 0 && col < cols && row >= 0 && row < rows)
            begin
                r.in_view   = 1'b1;
                r.pixel_col = SIZE_W'(col);
                r.pixel_row = SIZE_W'(row);
            end
        end
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic load_defaults();
        intrinsics.focal_x      = FOCAL_X_RST;
        intrinsics.focal_y      = FOCAL_Y_RST;
        intrinsics.center_x     = CENTER_X_RST;
        intrinsics.center_y     = CENTER_Y_RST;
        intrinsics.image_width  = WIDTH_RST;
        intrinsics.image_height = HEIGHT_RST;
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
        visible     = 0;
        load_defaults();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_defaults();
            projected_words.delete();
            outstanding = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (projected_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with no point outstanding, expected none, actual %h",
                             $time, result_word);
                end
                else
                begin
                    oldest = projected_words.pop_front();
                    compare_field("in_view", oldest.in_view, result_word.in_view);
                    compare_field("pixel_col", oldest.pixel_col, result_word.pixel_col);
                    compare_field("pixel_row", oldest.pixel_row, result_word.pixel_row);
                    compare_field("depth_code", oldest.depth_code, result_word.depth_code);
                    checked++;
                    if (oldest.in_view)
                        visible++;
                end
            end
            if (point_valid && point_ready)
                projected_words.push_back(project_point(point_word, intrinsics));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_word.index))
                    REG_FOCAL_X:      intrinsics.focal_x      = cfg_word.wdata[FOCAL_W-1:0];
                    REG_FOCAL_Y:      intrinsics.focal_y      = cfg_word.wdata[FOCAL_W-1:0];
                    REG_CENTER_X:     intrinsics.center_x     = cfg_word.wdata[CENTER_W-1:0];
                    REG_CENTER_Y:     intrinsics.center_y     = cfg_word.wdata[CENTER_W-1:0];
                    REG_IMAGE_WIDTH:  intrinsics.image_width  = cfg_word.wdata[SIZE_W-1:0];
                    REG_IMAGE_HEIGHT: intrinsics.image_height = cfg_word.wdata[SIZE_W-1:0];
                    default: ;
                endcase
            end
            outstanding = projected_words.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the depth point projector testbench: clock, reset, point and register stimulus, verdict.
module testbench;
    import dpp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_POINTS = 64;
    localparam logic [INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    logic      clk;
    logic      rst_n;
    int        mismatches;
    int        outstanding;
    int        checked;
    int        visible;
    int        cycles;
    int        send_idle;
    int        recv_stall;
    int        settings_used;
    cfg_regs_t aim;

    dpp_stream_if #(.payload_t(point_t))    point_if ();
    dpp_stream_if #(.payload_t(cfg_word_t)) cfg_if ();
    dpp_stream_if #(.payload_t(result_t))   result_if ();

    depth_point_projector_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_if),
        .cfg    (cfg_if),
        .result (result_if)
    );

    depth_projection_checker scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_if.valid),
        .point_ready  (point_if.ready),
        .point_word   (point_if.data),
        .cfg_valid    (cfg_if.valid),
        .cfg_ready    (cfg_if.ready),
        .cfg_word     (cfg_if.data),
        .result_valid (result_if.valid),
        .result_ready (result_if.ready),
        .result_word  (result_if.data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked),
        .visible      (visible)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_if.ready = ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic point_t mk_point(int x, int y, int z);
        point_t p;
        p.point_x = COORD_W'(x);
        p.point_y = COORD_W'(y);
        p.point_z = COORD_W'(z);
        return p;
    endfunction

    // aim at a pixel near the image, a little beyond each border
    function automatic logic [COORD_W-1:0] aim_axis(longint f, longint c, longint n, longint z);
        longint target;
        longint coord;
        target = longint'($urandom_range(n + n / 4 + 4)) - n / 8 - 2;
        if (f == 0)
            return COORD_W'($urandom);
        coord = ((target * 256 + longint'($urandom_range(255)) - c) * z) / f;
        if (coord > 32767)
            coord = 32767;
        if (coord < -32768)
            coord = -32768;
        return COORD_W'(coord);
    endfunction

    function automatic point_t random_point();
        point_t p;
        int     kind;
        longint z;
        kind = $urandom_range(9);
        if (kind < 2)
        begin
            p.point_x = COORD_W'($urandom);
            p.point_y = COORD_W'($urandom);
            p.point_z = COORD_W'($urandom);
        end
        else if (kind == 2)
        begin
            p.point_x = COORD_W'($urandom);
            p.point_y = COORD_W'($urandom);
            p.point_z = COORD_W'(-longint'($urandom_range(32768)));
        end
        else
        begin
            case ($urandom_range(3))
                0:       z = $urandom_range(64, 1);
                1:       z = $urandom_range(4600, 4400);
                2:       z = $urandom_range(8000, 100);
                default: z = $urandom_range(32767, 1);
            endcase
            p.point_z = COORD_W'(z);
            p.point_x = aim_axis(aim.focal_x, aim.center_x, aim.image_width, z);
            p.point_y = aim_axis(aim.focal_y, aim.center_y, aim.image_height, z);
        end
        return p;
    endfunction

    task automatic send_point(point_t p);
        while ($urandom_range(99) < send_idle)
        begin
            point_if.valid = 1'b0;
            @(negedge clk);
        end
        point_if.data  = p;
        point_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!point_if.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [WDATA_W-1:0] value);
        cfg_if.data.index = idx;
        cfg_if.data.wdata = value;
        cfg_if.valid      = 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        @(negedge clk);
        case (idx)
            REG_FOCAL_X:      aim.focal_x      = value[FOCAL_W-1:0];
            REG_FOCAL_Y:      aim.focal_y      = value[FOCAL_W-1:0];
            REG_CENTER_X:     aim.center_x     = value[CENTER_W-1:0];
            REG_CENTER_Y:     aim.center_y     = value[CENTER_W-1:0];
            REG_IMAGE_WIDTH:  aim.image_width  = value[SIZE_W-1:0];
            REG_IMAGE_HEIGHT: aim.image_height = value[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int k);
        logic [WDATA_W-1:0] fx;
        logic [WDATA_W-1:0] fy;
        logic [WDATA_W-1:0] cx;
        logic [WDATA_W-1:0] cy;
        logic [WDATA_W-1:0] w;
        logic [WDATA_W-1:0] h;
        case (k)
            0:
            begin
                fx = WDATA_W'(525 * 256);
                fy = WDATA_W'(525 * 256);
                cx = WDATA_W'(320 * 256);
                cy = WDATA_W'(240 * 256);
                w  = WDATA_W'(640);
                h  = WDATA_W'(480);
            end
            1:
            begin
                fx = '1;
                fy = '1;
                cx = '1;
                cy = '1;
                w  = '1;
                h  = '1;
            end
            2:
            begin
                fx = '0;
                fy = '0;
                cx = '0;
                cy = '0;
                w  = WDATA_W'(1);
                h  = WDATA_W'(1);
            end
            3:
            begin
                fx = WDATA_W'($urandom);
                fy = WDATA_W'($urandom);
                cx = WDATA_W'($urandom);
                cy = WDATA_W'($urandom);
                // upper bits drop, leaving an empty image
                w  = 24'h001000;
                h  = 24'hFFF000;
            end
            default:
            begin
                fx = WDATA_W'($urandom);
                fy = WDATA_W'($urandom);
                cx = WDATA_W'($urandom);
                cy = WDATA_W'($urandom);
                w  = WDATA_W'($urandom);
                h  = WDATA_W'($urandom);
            end
        endcase
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        if (k == 3)
        begin
            write_reg(REG_SPARE_LO, WDATA_W'($urandom));
            write_reg(REG_SPARE_HI, WDATA_W'($urandom));
        end
        cfg_if.valid = 1'b0;
        settings_used++;
    endtask

    task automatic wait_idle();
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        point_if.valid = 1'b0;
        point_if.data  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        send_idle      = 0;
        recv_stall     = 0;
        settings_used  = 1;
        aim.focal_x      = FOCAL_X_RST;
        aim.focal_y      = FOCAL_Y_RST;
        aim.center_x     = CENTER_X_RST;
        aim.center_y     = CENTER_Y_RST;
        aim.image_width  = WIDTH_RST;
        aim.image_height = HEIGHT_RST;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_point(mk_point(0, 0, 0));
        send_point(mk_point(100, 100, -1));
        send_point(mk_point(32767, -32768, -32768));
        send_point(mk_point(0, 0, 1));
        send_point(mk_point(0, 0, 17));
        send_point(mk_point(0, 0, 18));
        send_point(mk_point(0, 0, 4482));
        send_point(mk_point(0, 0, 4483));
        send_point(mk_point(0, 0, 4500));
        send_point(mk_point(0, 0, 32767));
        send_point(mk_point(-160, 0, 512));
        send_point(mk_point(-161, 0, 512));
        send_point(mk_point(159, 0, 512));
        send_point(mk_point(160, 0, 512));
        send_point(mk_point(0, -90, 512));
        send_point(mk_point(0, 89, 512));
        send_point(mk_point(0, 90, 512));
        send_point(mk_point(-321, 0, 1024));
        send_point(mk_point(32767, 32767, 1));
        send_point(mk_point(-32768, -32768, 1));
        send_point(mk_point(-1, -1, 32767));
        send_point(mk_point(300, 200, 1000));
        point_if.valid = 1'b0;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            apply_setting(phase);
            case (phase % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 67;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 67;
                end
                default:
                begin
                    send_idle  = 35;
                    recv_stall = 35;
                end
            endcase
            for (int n = 0; n < PHASE_POINTS; n++)
                send_point(random_point());
            point_if.valid = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Projected %0d points under %0d register settings; %0d fell inside the image.",
                 checked, settings_used, visible);
        $display("Field mismatches: %0d, results still awaited: %0d", mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
